// ----- src/gsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gsc_pkg;

   // defaults for the top-level parameters
   localparam int MAX_SLOTS_DEF = 256;
   localparam int CODE_BITS_DEF = 16;

   // fixed field widths
   localparam int CHAR_W     = 16;
   localparam int SLOT_OUT_W = 8;
   localparam int TEXEL_W    = 12;
   localparam int FONT_W     = 9;
   localparam int ROWS_RAW_W = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_PER_ROW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FONT_SIZE     = 2'd1;

   // register reset values and limits
   localparam logic [ROWS_RAW_W-1:0] ROWS_RAW_RST = 5'd16;
   localparam logic [FONT_W-1:0]     FONT_RST     = 9'd16;
   localparam logic [FONT_W-1:0]     FONT_MAX     = 9'd256;

   // victim LFSR and shared divider
   localparam int               LFSR_W    = 16;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam int               DIV_STEPS = LFSR_W / 2;   // two quotient bits per cycle
   localparam int               DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SETTLE,
      ST_WRITE,
      ST_COORD,
      ST_CWAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;     // latch request, start victim divide
      logic scan;      // walk tag banks
      logic place;     // pick slot for a miss
      logic write;     // write tag, bump fill or LFSR
      logic coord;     // start slot / rows divide
      logic load_out;  // load response register
   } cmd_type;

   typedef struct packed {
      logic scan_hit;
      logic scan_end;
      logic hit;
      logic div_busy;
   } stat_type;

   function automatic int lane_count(int slots);
      int n;
      n = (slots >= 16) ? 16 : 4;
      return n;
   endfunction

   function automatic int min_w(int n);
      int w;
      w = (n > 1) ? $clog2(n) : 1;
      return w;
   endfunction

   function automatic int max_rows(int slots);
      int r;
      r = 1;
      for (int i = 1; i <= 32; i++) begin
         if (i * i <= slots) begin
            r = i;
         end
      end
      return r;
   endfunction

   function automatic int rows_reset(int slots);
      int m;
      int r;
      m = max_rows(slots);
      r = (int'(ROWS_RAW_RST) > m) ? m : int'(ROWS_RAW_RST);
      return r;
   endfunction

   // Fibonacci LFSR, taps 16,14,13,11
   function automatic logic [LFSR_W-1:0] lfsr_next(logic [LFSR_W-1:0] v);
      logic b;
      b = v[0] ^ v[2] ^ v[3] ^ v[5];
      return {b, v[LFSR_W-1:1]};
   endfunction

endpackage

`default_nettype wire

// ----- src/gsc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                           clock,
   input  wire logic                           we,
   input  wire logic [gsc_pkg::min_w(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]               wdata,
   input  wire logic                           re,
   input  wire logic [gsc_pkg::min_w(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]               rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- src/gsc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, 16-bit dividend, two quotient bits per cycle
module gsc_div #(
   parameter int DEN_W = 9
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [gsc_pkg::LFSR_W-1:0] num,
   input  wire logic [DEN_W-1:0]           den,
   output logic                            busy,
   output logic      [gsc_pkg::LFSR_W-1:0] quot,
   output logic      [DEN_W-1:0]           rem
);

   localparam int NW = gsc_pkg::LFSR_W;

   logic                          busy_ff, busy_in;
   logic [gsc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]                 num_ff, num_in;
   logic [NW-1:0]                 quot_ff, quot_in;
   logic [DEN_W-1:0]              den_ff, den_in;
   logic [DEN_W-1:0]              rem_ff, rem_in;
   logic [DEN_W-1:0]              rem_mid;
   logic                          q_hi, q_lo;

   function automatic logic [DEN_W:0] div_step(logic [DEN_W-1:0] r, logic b,
                                               logic [DEN_W-1:0] d);
      logic [DEN_W:0] part;
      logic [DEN_W:0] diff;
      part = {r, b};
      diff = part - {1'b0, d};
      if (part >= {1'b0, d}) begin
         return {1'b1, diff[DEN_W-1:0]};
      end
      return {1'b0, part[DEN_W-1:0]};
   endfunction

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      {q_hi, rem_mid} = div_step(rem_ff, num_ff[NW-1], den_ff);
      {q_lo, rem_in}  = div_step(rem_mid, num_ff[NW-2], den_ff);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = gsc_pkg::DIV_CNT_W'(gsc_pkg::DIV_STEPS - 1);
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in  = {num_ff[NW-3:0], 2'b00};
         quot_in = {quot_ff[NW-3:0], q_hi, q_lo};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end else begin
         rem_in = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

// ----- src/gsc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gsc_datapath #(
   parameter int MAX_SLOTS = gsc_pkg::MAX_SLOTS_DEF,
   parameter int CODE_BITS = gsc_pkg::CODE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [gsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [gsc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic [gsc_pkg::CHAR_W-1:0]          req_char_code,
   input  wire gsc_pkg::cmd_type                    cmd,
   output gsc_pkg::stat_type                        stat,
   output logic                                     rsp_hit,
   output logic                                     rsp_evicted,
   output logic      [gsc_pkg::SLOT_OUT_W-1:0]      rsp_slot_index,
   output logic      [gsc_pkg::TEXEL_W-1:0]         rsp_texel_x,
   output logic      [gsc_pkg::TEXEL_W-1:0]         rsp_texel_y
);

   localparam int LANES      = gsc_pkg::lane_count(MAX_SLOTS);
   localparam int LANE_W     = $clog2(LANES);
   localparam int BANK_DEPTH = (MAX_SLOTS + LANES - 1) / LANES;
   localparam int BANK_AW    = gsc_pkg::min_w(BANK_DEPTH);
   localparam int SLOT_W     = BANK_AW + LANE_W;
   localparam int FILL_W     = SLOT_W + 1;
   localparam int ROW_W      = BANK_AW + 1;
   localparam int DEN_W      = SLOT_W + 1;
   localparam int MAX_ROWS   = gsc_pkg::max_rows(MAX_SLOTS);
   localparam int ROWS_W     = $clog2(MAX_ROWS + 1);
   localparam int ROWS_RST   = gsc_pkg::rows_reset(MAX_SLOTS);
   localparam int PROD_W     = gsc_pkg::TEXEL_W + gsc_pkg::FONT_W;
   localparam int NW         = gsc_pkg::LFSR_W;

   // configuration, held in effective (clamped) form
   logic [ROWS_W-1:0]          rows_ff, rows_in;
   logic [gsc_pkg::FONT_W-1:0] font_ff, font_in;
   logic [DEN_W-1:0]           total_ff, total_in;
   logic [FILL_W-1:0]          fill_ff;
   logic [NW-1:0]              lfsr_ff;

   // request and scan
   logic [CODE_BITS-1:0]       code_ff;
   logic [ROW_W-1:0]           rd_row_ff;
   logic                       cmp_vld_ff;
   logic [BANK_AW-1:0]         cmp_row_ff;
   logic                       hit_ff;
   logic                       evicted_ff;
   logic [SLOT_W-1:0]          slot_ff;

   // response register
   logic                          rsp_hit_ff, rsp_evicted_ff;
   logic [gsc_pkg::SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [gsc_pkg::TEXEL_W-1:0]   rsp_x_ff, rsp_y_ff;

   logic [CODE_BITS-1:0]  bank_rdata [LANES];
   logic [LANES-1:0]      lane_hit;
   logic [LANE_W-1:0]     hit_lane;
   logic [FILL_W:0]       fill_round;
   logic [ROW_W:0]        scan_rows;
   logic                  issue;
   logic                  full;
   logic [BANK_AW-1:0]    rd_addr;
   logic [BANK_AW-1:0]    wr_addr;

   logic                  div_start;
   logic [NW-1:0]         div_num;
   logic [DEN_W-1:0]      div_den;
   logic                  div_busy;
   logic [NW-1:0]         div_quot;
   logic [DEN_W-1:0]      div_rem;

   logic [gsc_pkg::TEXEL_W-1:0] tx_col;
   logic [PROD_W-1:0]          x_prod, y_prod;

   // clamp incoming register values
   always_comb begin
      logic [5:0] raw_rows;
      raw_rows = 6'(csr_wdata[gsc_pkg::ROWS_RAW_W-1:0]);
      if (raw_rows == '0) begin
         rows_in = ROWS_W'(1);
      end else if (raw_rows > 6'(MAX_ROWS)) begin
         rows_in = ROWS_W'(MAX_ROWS);
      end else begin
         rows_in = ROWS_W'(raw_rows);
      end
      total_in = DEN_W'(rows_in) * DEN_W'(rows_in);
      if (csr_wdata == '0) begin
         font_in = gsc_pkg::FONT_W'(1);
      end else if (csr_wdata > gsc_pkg::FONT_MAX) begin
         font_in = gsc_pkg::FONT_MAX;
      end else begin
         font_in = csr_wdata;
      end
   end

   // valid slots always form a prefix [0, fill)
   assign fill_round = {1'b0, fill_ff} + (FILL_W + 1)'(LANES - 1);
   assign scan_rows  = fill_round[FILL_W:LANE_W];
   assign issue      = ({1'b0, rd_row_ff} < scan_rows);
   assign full       = (fill_ff == FILL_W'(total_ff));
   assign rd_addr    = rd_row_ff[BANK_AW-1:0];
   assign wr_addr    = slot_ff[SLOT_W-1:LANE_W];

   always_comb begin
      hit_lane = '0;
      for (int l = 0; l < LANES; l++) begin
         lane_hit[l] = cmp_vld_ff
                    && ({1'b0, cmp_row_ff, LANE_W'(l)} < fill_ff)
                    && (bank_rdata[l] == code_ff);
      end
      for (int l = LANES - 1; l >= 0; l--) begin
         if (lane_hit[l]) begin
            hit_lane = LANE_W'(l);
         end
      end
   end

   generate
      for (genvar g = 0; g < LANES; g++) begin : g_bank
         gsc_ram #(
            .WIDTH (CODE_BITS),
            .DEPTH (BANK_DEPTH)
         ) u_ram (
            .clock (clock),
            .we    (cmd.write && (slot_ff[LANE_W-1:0] == LANE_W'(g))),
            .waddr (wr_addr),
            .wdata (code_ff),
            .re    (cmd.scan && issue),
            .raddr (rd_addr),
            .rdata (bank_rdata[g])
         );
      end
   endgenerate

   // shared divider: victim = lfsr' % total, then slot / rows
   assign div_start = cmd.start || cmd.coord;
   assign div_num   = cmd.coord ? NW'(slot_ff) : gsc_pkg::lfsr_next(lfsr_ff);
   assign div_den   = cmd.coord ? DEN_W'(rows_ff) : total_ff;

   gsc_div #(
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   assign tx_col = gsc_pkg::TEXEL_W'(div_rem);
   assign x_prod = PROD_W'(tx_col) * PROD_W'(font_ff);
   assign y_prod = PROD_W'(div_quot[gsc_pkg::TEXEL_W-1:0]) * PROD_W'(font_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= ROWS_W'(ROWS_RST);
         total_ff   <= DEN_W'(ROWS_RST * ROWS_RST);
         font_ff    <= gsc_pkg::FONT_RST;
         fill_ff    <= '0;
         lfsr_ff    <= gsc_pkg::LFSR_SEED;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         if (csr_we && csr_index == gsc_pkg::CSR_SLOTS_PER_ROW) begin
            rows_ff  <= rows_in;
            total_ff <= total_in;
            fill_ff  <= '0;
         end else if (csr_we && csr_index == gsc_pkg::CSR_FONT_SIZE) begin
            font_ff <= font_in;
            fill_ff <= '0;
         end else if (cmd.write && !evicted_ff) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.write && evicted_ff) begin
            lfsr_ff <= gsc_pkg::lfsr_next(lfsr_ff);
         end
         if (cmd.start) begin
            cmp_vld_ff <= 1'b0;
            hit_ff     <= 1'b0;
         end else if (cmd.scan) begin
            cmp_vld_ff <= issue;
            if (|lane_hit) begin
               hit_ff <= 1'b1;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         code_ff    <= CODE_BITS'(req_char_code);
         rd_row_ff  <= '0;
         evicted_ff <= 1'b0;
      end
      if (cmd.scan) begin
         if (issue) begin
            rd_row_ff <= rd_row_ff + 1'b1;
         end
         cmp_row_ff <= rd_addr;
         if (|lane_hit) begin
            slot_ff <= {cmp_row_ff, hit_lane};
         end
      end
      if (cmd.place) begin
         evicted_ff <= full;
         slot_ff    <= full ? div_rem[SLOT_W-1:0] : fill_ff[SLOT_W-1:0];
      end
      if (cmd.load_out) begin
         rsp_hit_ff     <= hit_ff;
         rsp_evicted_ff <= evicted_ff;
         rsp_slot_ff    <= gsc_pkg::SLOT_OUT_W'(slot_ff);
         rsp_x_ff       <= x_prod[gsc_pkg::TEXEL_W-1:0];
         rsp_y_ff       <= y_prod[gsc_pkg::TEXEL_W-1:0];
      end
   end

   assign stat.scan_hit = cmd.scan && (|lane_hit);
   assign stat.scan_end = !cmp_vld_ff && !issue;
   assign stat.hit      = hit_ff;
   assign stat.div_busy = div_busy;

   assign rsp_hit        = rsp_hit_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_texel_x    = rsp_x_ff;
   assign rsp_texel_y    = rsp_y_ff;

endmodule

`default_nettype wire

// ----- src/gsc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gsc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire gsc_pkg::stat_type stat,
   output gsc_pkg::cmd_type       cmd
);

   gsc_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         gsc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = gsc_pkg::ST_SCAN;
            end
         end
         gsc_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_hit || stat.scan_end) begin
               state_in = gsc_pkg::ST_SETTLE;
            end
         end
         gsc_pkg::ST_SETTLE: begin
            // victim divide must finish before the divider is reused
            if (!stat.div_busy) begin
               if (stat.hit) begin
                  state_in = gsc_pkg::ST_COORD;
               end else begin
                  cmd.place = 1'b1;
                  state_in  = gsc_pkg::ST_WRITE;
               end
            end
         end
         gsc_pkg::ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = gsc_pkg::ST_COORD;
         end
         gsc_pkg::ST_COORD: begin
            cmd.coord = 1'b1;
            state_in  = gsc_pkg::ST_CWAIT;
         end
         gsc_pkg::ST_CWAIT: begin
            if (!stat.div_busy) begin
               state_in = gsc_pkg::ST_OUT;
            end
         end
         gsc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = gsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gsc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- src/glyph_slot_cache.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Glyph slot cache: a fully associative cache that maps character codes onto
// a square grid of glyph slots (slots_per_row squared, clamped to what
// MAX_SLOTS holds). Each request carries one code; the response says whether
// it hit, whether a valid slot was evicted at random, the slot number and the
// slot's texel origin (column and row times font_size, 12 bits each). A miss
// takes the lowest free slot; once the grid is full the victim is a 16-bit
// LFSR value modulo the slot count. Writing either register empties the
// cache. Requests are handled one at a time. The tag walk reads all banks in
// parallel, 16 banks and 16 tags per cycle (4 banks when MAX_SLOTS is under
// 16), and covers only the filled rows, but the victim divide started at the
// accept on the shared two-bit-per-cycle divider must settle before a miss is
// placed or a hit goes on. For a miss the tag write, the slot / rows divide
// and the response load follow. A hit skips the tag write and stops the walk
// at its row. A stalled response holds the block until the output register
// is free. A new request is taken while the previous response still waits in
// the output register.

module glyph_slot_cache #(
   parameter int MAX_SLOTS = gsc_pkg::MAX_SLOTS_DEF,
   parameter int CODE_BITS = gsc_pkg::CODE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration
   input  wire logic                            csr_we,
   input  wire logic [gsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [gsc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // request
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [gsc_pkg::CHAR_W-1:0]      req_char_code,
   // response
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_hit,
   output logic                                 rsp_evicted,
   output logic      [gsc_pkg::SLOT_OUT_W-1:0]  rsp_slot_index,
   output logic      [gsc_pkg::TEXEL_W-1:0]     rsp_texel_x,
   output logic      [gsc_pkg::TEXEL_W-1:0]     rsp_texel_y
);

   gsc_pkg::cmd_type  cmd;
   gsc_pkg::stat_type stat;

   // sequencer: scan, place, write, coordinate divide, response
   gsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // tag banks, fill count, LFSR, divider, texel multipliers
   gsc_datapath #(
      .MAX_SLOTS (MAX_SLOTS),
      .CODE_BITS (CODE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_char_code  (req_char_code),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_hit        (rsp_hit),
      .rsp_evicted    (rsp_evicted),
      .rsp_slot_index (rsp_slot_index),
      .rsp_texel_x    (rsp_texel_x),
      .rsp_texel_y    (rsp_texel_y)
   );

   // the divider is never restarted while a divide is in flight
   a_coord_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.coord |-> !stat.div_busy)
      else $error("coordinate divide started while divider busy");

   // a miss is placed only after the victim divide has settled
   a_place_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> !stat.div_busy)
      else $error("slot placed while victim divide still running");

   // one request in flight: after an accept the input side stalls
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request accepted while busy");

   // a response is never both a hit and an eviction
   a_hit_xor_evict: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> !(rsp_hit && rsp_evicted))
      else $error("response flags both hit and eviction");

endmodule

`default_nettype wire
